FILE: sv/mtu_pkg.sv
// -----------------------------------------------------------------------------
// mtu_pkg
// Shared types and constants of the multi-turn unwrap and velocity estimator.
// -----------------------------------------------------------------------------
package mtu_pkg;

	localparam int DEF_ACC_WIDTH  = 40;
	localparam int DEF_RAW_BITS   = 12;
	localparam int RAW_WORD_WIDTH = 16;
	localparam int ALPHA_WIDTH    = 17;
	localparam int FRAC_BITS      = 16;
	localparam int CFG_IDX_WIDTH  = 1;
	localparam int CFG_DATA_WIDTH = ALPHA_WIDTH;
	localparam int FAULT_WIDTH    = 3;

	localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE = ALPHA_WIDTH'(1) << FRAC_BITS;

	typedef enum logic [FAULT_WIDTH-1:0] {
		FAULT_NONE     = 3'd0,
		FAULT_BUS      = 3'd1,
		FAULT_MAG_LOST = 3'd2,
		FAULT_WEAK     = 3'd3,
		FAULT_STRONG   = 3'd4
	} fault_t;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_INVERT = 1'b0,
		CFG_WEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ACT_SAMPLE = 1'b0,
		ACT_CLEAR  = 1'b1
	} action_t;

	typedef struct packed {
		logic                      action;
		logic [RAW_WORD_WIDTH-1:0] raw_angle;
		logic                      bus_ok;
		logic                      mag_present;
		logic                      mag_low;
		logic                      mag_high;
	} sample_t;

	typedef struct packed {
		fault_t fault;
		logic   seeded;
	} status_t;

endpackage

FILE: sv/mtu_ifs.sv
// -----------------------------------------------------------------------------
// mtu_ifs
// Valid/ready channels: incoming sensor samples and outgoing estimates.
// -----------------------------------------------------------------------------
interface mtu_in_if;
	logic                               valid;
	logic                               ready;
	logic                               action;
	logic [mtu_pkg::RAW_WORD_WIDTH-1:0] raw_angle;
	logic                               bus_ok;
	logic                               mag_present;
	logic                               mag_low;
	logic                               mag_high;

	modport source (output valid, action, raw_angle, bus_ok, mag_present,
		mag_low, mag_high, input ready);
	modport sink (input valid, action, raw_angle, bus_ok, mag_present,
		mag_low, mag_high, output ready);
endinterface

interface mtu_out_if #(
	parameter int ACC_WIDTH = mtu_pkg::DEF_ACC_WIDTH,
	parameter int RAW_BITS  = mtu_pkg::DEF_RAW_BITS
);
	logic                                  valid;
	logic                                  ready;
	logic [mtu_pkg::FAULT_WIDTH-1:0]       fault_code;
	logic signed [ACC_WIDTH-1:0]           pos_count;
	logic signed [ACC_WIDTH-RAW_BITS-1:0]  turns;
	logic signed [RAW_BITS+16:0]           velocity;
	logic                                  seeded;

	modport source (output valid, fault_code, pos_count, turns, velocity, seeded,
		input ready);
	modport sink (input valid, fault_code, pos_count, turns, velocity, seeded,
		output ready);
endinterface

FILE: sv/mtu_update.sv
// -----------------------------------------------------------------------------
// mtu_update
// Next-state logic for one sample: fault classification, shortest-path unwrap,
// saturating count and the Q16 velocity IIR.
// -----------------------------------------------------------------------------
module mtu_update #(
	parameter int ACC_WIDTH = mtu_pkg::DEF_ACC_WIDTH,
	parameter int RAW_BITS  = mtu_pkg::DEF_RAW_BITS
) (
	input  mtu_pkg::sample_t                   item,
	input  logic                               invert,
	input  logic [mtu_pkg::ALPHA_WIDTH-1:0]    filt_weight,
	input  mtu_pkg::status_t                   status_q,
	input  logic [RAW_BITS-1:0]                prev_q,
	input  logic signed [ACC_WIDTH-1:0]        acc_q,
	input  logic signed [RAW_BITS+16:0]        vel_q,
	output mtu_pkg::status_t                   status_d,
	output logic [RAW_BITS-1:0]                prev_d,
	output logic signed [ACC_WIDTH-1:0]        acc_d,
	output logic signed [RAW_BITS+16:0]        vel_d
);
	import mtu_pkg::*;

	localparam int DW   = RAW_BITS + 1;
	localparam int VW   = RAW_BITS + 17;
	localparam int DIFW = VW + 1;
	localparam int PW   = DIFW + ALPHA_WIDTH + 1;
	localparam int SW   = VW + 4;
	localparam logic signed [RAW_BITS+1:0] HALF = (RAW_BITS+2)'(1) << (RAW_BITS - 1);
	localparam logic signed [RAW_BITS+1:0] FULL = (RAW_BITS+2)'(1) << RAW_BITS;

	fault_t                      fault;
	logic [RAW_BITS-1:0]         r;
	logic signed [RAW_BITS+1:0]  d_raw;
	logic signed [RAW_BITS+1:0]  d_wrap;
	logic signed [DW-1:0]        delta;
	logic signed [DW-1:0]        delta_dir;
	logic signed [ACC_WIDTH:0]   acc_sum;
	logic signed [ACC_WIDTH-1:0] acc_sat;
	logic signed [VW-1:0]        rawvel;
	logic signed [DIFW-1:0]      diff;
	logic signed [PW-1:0]        prod;
	logic signed [PW-1:0]        prod_sh;
	logic signed [SW-1:0]        vsum;
	logic signed [VW-1:0]        vel_new;

	always_comb begin
		priority if (!item.bus_ok) begin
			fault = FAULT_BUS;
		end else if (!item.mag_present) begin
			fault = FAULT_MAG_LOST;
		end else if (item.mag_low) begin
			fault = FAULT_WEAK;
		end else if (item.mag_high) begin
			fault = FAULT_STRONG;
		end else begin
			fault = FAULT_NONE;
		end
	end

	// shortest path; an exact half revolution keeps its sign
	assign r     = item.raw_angle[RAW_BITS-1:0];
	assign d_raw = $signed({2'b00, r}) - $signed({2'b00, prev_q});

	always_comb begin
		priority if (d_raw > HALF) begin
			d_wrap = d_raw - FULL;
		end else if (d_raw < -HALF) begin
			d_wrap = d_raw + FULL;
		end else begin
			d_wrap = d_raw;
		end
	end

	assign delta     = d_wrap[DW-1:0];
	assign delta_dir = invert ? -delta : delta;

	assign acc_sum = (ACC_WIDTH+1)'(acc_q) + (ACC_WIDTH+1)'(delta_dir);

	always_comb begin
		if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1]) begin
			acc_sat = acc_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
				: {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end else begin
			acc_sat = acc_sum[ACC_WIDTH-1:0];
		end
	end

	// v += (alpha * (delta<<16 - v)) >>> 16, floor rounding
	assign rawvel  = {delta_dir, {FRAC_BITS{1'b0}}};
	assign diff    = DIFW'(rawvel) - DIFW'(vel_q);
	assign prod    = PW'($signed({1'b0, filt_weight})) * PW'(diff);
	assign prod_sh = prod >>> FRAC_BITS;
	assign vsum    = SW'(vel_q) + prod_sh[SW-1:0];

	always_comb begin
		if (!(&vsum[SW-1:VW-1]) && (|vsum[SW-1:VW-1])) begin
			vel_new = vsum[SW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
		end else begin
			vel_new = vsum[VW-1:0];
		end
	end

	always_comb begin
		status_d = status_q;
		prev_d   = prev_q;
		acc_d    = acc_q;
		vel_d    = vel_q;
		if (item.action == ACT_CLEAR) begin
			status_d.seeded = 1'b0;
			acc_d           = '0;
			vel_d           = '0;
		end else begin
			status_d.fault = fault;
			if (fault == FAULT_BUS || fault == FAULT_MAG_LOST) begin
				vel_d = '0;
			end else if (!status_q.seeded) begin
				status_d.seeded = 1'b1;
				prev_d          = r;
				acc_d           = '0;
				vel_d           = '0;
			end else begin
				prev_d = r;
				acc_d  = acc_sat;
				vel_d  = vel_new;
			end
		end
	end

endmodule

FILE: sv/mtu_result.sv
// -----------------------------------------------------------------------------
// mtu_result
// Result stage: valid flag over the estimator state, turn count derivation and
// the outgoing channel.
// -----------------------------------------------------------------------------
module mtu_result #(
	parameter int ACC_WIDTH = mtu_pkg::DEF_ACC_WIDTH,
	parameter int RAW_BITS  = mtu_pkg::DEF_RAW_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	output logic                        free,
	input  mtu_pkg::status_t            status_q,
	input  logic signed [ACC_WIDTH-1:0] acc_q,
	input  logic signed [RAW_BITS+16:0] vel_q,
	mtu_out_if.source                   res
);
	import mtu_pkg::*;

	localparam logic [ACC_WIDTH-1:0] ROUND = {{(ACC_WIDTH-RAW_BITS){1'b0}}, {RAW_BITS{1'b1}}};

	logic                 valid_q;
	logic [ACC_WIDTH-1:0] acc_adj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	assign free = !valid_q || res.ready;

	// bias negative counts so the shift truncates toward zero
	assign acc_adj = acc_q[ACC_WIDTH-1] ? acc_q + ROUND : acc_q;

	assign res.valid      = valid_q;
	assign res.fault_code = status_q.fault;
	assign res.seeded     = status_q.seeded;
	assign res.pos_count  = acc_q;
	assign res.turns      = acc_adj[ACC_WIDTH-1:RAW_BITS];
	assign res.velocity   = vel_q;

endmodule

FILE: sv/multiturn_encoder_unwrap_estimator.sv
// -----------------------------------------------------------------------------
// multiturn_encoder_unwrap_estimator
// Turns a stream of absolute angle samples into a multi-turn position and a
// filtered velocity. Each transaction on the sample channel is registered,
// then classified, unwrapped, accumulated and filtered by combinational logic,
// and produces exactly one transaction on the result channel. One sample is
// taken every clock cycle while the result channel keeps up; the estimate
// passes through the input register and then the state register, which
// presents it. The rate is set by the update loop through the unwrap, the
// saturating count and the 17 x (RAW_BITS+18) bit IIR multiplier. A stalled
// result holds the update; one more sample is then taken into the input
// register before the sample channel stalls too. The estimator state itself
// is the result register, so the reported values are the state after that
// sample. The invert and smoothing weight registers must only be written
// while no transaction is in flight.
// -----------------------------------------------------------------------------
module multiturn_encoder_unwrap_estimator #(
	parameter int ACC_WIDTH = mtu_pkg::DEF_ACC_WIDTH,
	parameter int RAW_BITS  = mtu_pkg::DEF_RAW_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	mtu_in_if.sink                              sample,
	mtu_out_if.source                           result,
	input  logic                                cfg_we,
	input  logic [mtu_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
	input  logic [mtu_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
	import mtu_pkg::*;

	logic                        invert_q;
	logic [ALPHA_WIDTH-1:0]      weight_q;
	sample_t                     item_s1;
	logic                        valid_s1;
	logic                        advance;
	logic                        res_free;
	status_t                     status_q;
	status_t                     status_d;
	logic [RAW_BITS-1:0]         prev_q;
	logic [RAW_BITS-1:0]         prev_d;
	logic signed [ACC_WIDTH-1:0] acc_q;
	logic signed [ACC_WIDTH-1:0] acc_d;
	logic signed [RAW_BITS+16:0] vel_q;
	logic signed [RAW_BITS+16:0] vel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
			weight_q <= ALPHA_ONE;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_INVERT: invert_q <= cfg_data[0];
				CFG_WEIGHT: weight_q <= cfg_data[ALPHA_WIDTH-1:0];
			endcase
		end
	end

	assign advance      = valid_s1 && res_free;
	assign sample.ready = !valid_s1 || res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			item_s1 <= '{action: sample.action, raw_angle: sample.raw_angle,
				bus_ok: sample.bus_ok, mag_present: sample.mag_present,
				mag_low: sample.mag_low, mag_high: sample.mag_high};
		end
	end

	mtu_update #(.ACC_WIDTH(ACC_WIDTH), .RAW_BITS(RAW_BITS)) u_update (
		.item        (item_s1),
		.invert      (invert_q),
		.filt_weight (weight_q),
		.status_q    (status_q),
		.prev_q      (prev_q),
		.acc_q       (acc_q),
		.vel_q       (vel_q),
		.status_d    (status_d),
		.prev_d      (prev_d),
		.acc_d       (acc_d),
		.vel_d       (vel_d)
	);

	// estimator state doubles as the result payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '{fault: FAULT_NONE, seeded: 1'b0};
			prev_q   <= '0;
			acc_q    <= '0;
			vel_q    <= '0;
		end else if (advance) begin
			status_q <= status_d;
			prev_q   <= prev_d;
			acc_q    <= acc_d;
			vel_q    <= vel_d;
		end
	end

	mtu_result #(.ACC_WIDTH(ACC_WIDTH), .RAW_BITS(RAW_BITS)) u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.free     (res_free),
		.status_q (status_q),
		.acc_q    (acc_q),
		.vel_q    (vel_q),
		.res      (result)
	);

endmodule

FILE: sv/mtu_checker.sv
// -----------------------------------------------------------------------------
// mtu_checker
// Port-level checks of the estimator, bound to the top level.
// -----------------------------------------------------------------------------
module mtu_checker #(
	parameter int ACC_WIDTH = mtu_pkg::DEF_ACC_WIDTH,
	parameter int RAW_BITS  = mtu_pkg::DEF_RAW_BITS
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [mtu_pkg::FAULT_WIDTH-1:0]      fault_code,
	input logic signed [ACC_WIDTH-1:0]          pos_count,
	input logic signed [ACC_WIDTH-RAW_BITS-1:0] turns,
	input logic signed [RAW_BITS+16:0]          velocity,
	input logic                                 seeded
);
	import mtu_pkg::*;

	// hold a stalled result unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_count)
			&& $stable(velocity) && $stable(fault_code) && $stable(seeded))
		else $error("stalled result changed");

	a_unseeded_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seeded |-> pos_count == '0 && velocity == '0)
		else $error("unseeded estimator reports motion");

	a_hard_fault_still: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fault_code == FAULT_BUS || fault_code == FAULT_MAG_LOST)
			|-> velocity == '0)
		else $error("velocity not zeroed on hard fault");

	a_turn_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> turns == '0
			|| turns[ACC_WIDTH-RAW_BITS-1] == pos_count[ACC_WIDTH-1])
		else $error("turn count sign disagrees with counts");

endmodule

bind multiturn_encoder_unwrap_estimator mtu_checker #(
	.ACC_WIDTH(ACC_WIDTH),
	.RAW_BITS (RAW_BITS)
) u_mtu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.fault_code (result.fault_code),
	.pos_count  (result.pos_count),
	.turns      (result.turns),
	.velocity   (result.velocity),
	.seeded     (result.seeded)
);

FILE: tb/tb_multiturn_encoder_unwrap_estimator.sv
// -----------------------------------------------------------------------------
// tb_multiturn_encoder_unwrap_estimator
// Self-checking bench for the multi-turn unwrap and velocity estimator. Sensor
// samples go in on the sample channel with random gaps. Each estimate on the
// result channel is checked against an in-bench model of the fault priority,
// the seeding, the shortest-path unwrap, the saturating count and the Q16 IIR.
// Directed corner cases come first, then random sensor traffic over several
// register settings, with random stalls on the result channel in all phases but one.
// -----------------------------------------------------------------------------
module tb_multiturn_encoder_unwrap_estimator;
	timeunit 1ns;
	timeprecision 1ps;

	import mtu_pkg::*;

	localparam int    ACC   = DEF_ACC_WIDTH;
	localparam int    RB    = DEF_RAW_BITS;
	localparam int    VW    = RB + 17;
	localparam longint FULL_TURN = longint'(1) << RB;
	localparam longint HALF_TURN = FULL_TURN / 2;
	localparam longint CNT_MAX   = (longint'(1) << (ACC - 1)) - 1;
	localparam longint CNT_MIN   = -CNT_MAX - 1;
	localparam longint VEL_MAX   = (longint'(1) << (VW - 1)) - 1;
	localparam longint VEL_MIN   = -VEL_MAX - 1;
	localparam int    STALL_LIMIT  = 2000;
	localparam int    RANDOM_ITEMS = 170;
	localparam int    SAMPLE_BITS  = $bits(sample_t);

	typedef struct {
		logic [FAULT_WIDTH-1:0] fault;
		logic signed [ACC-1:0]  total;
		logic signed [ACC-RB-1:0] turns;
		logic signed [VW-1:0]   vel;
		logic                   seeded;
	} estimate_t;

	class unwrap_tracker;
		bit              seeded;
		logic [RB-1:0]   prev_raw;
		longint          count;
		longint          vel;
		fault_t          last_code;
		bit              invert;
		int unsigned     alpha;
		estimate_t       estimates_due[$];
		int              mismatches;
		int              samples;
		int              clears;
		int              hard_faults;
		int              vel_clamps;

		function new();
			seeded    = 1'b0;
			prev_raw  = '0;
			count     = 0;
			vel       = 0;
			last_code = FAULT_NONE;
			invert    = 1'b0;
			alpha     = 65536;
		endfunction

		function void configure(bit inv, int unsigned a);
			invert = inv;
			alpha  = a;
		endfunction

		function int pending();
			return estimates_due.size();
		endfunction

		function void take_sample(sample_t s);
			estimate_t     e;
			logic [RB-1:0] r;
			longint        d;
			longint        v;
			samples++;
			if (s.action == ACT_CLEAR) begin
				seeded = 1'b0;
				count  = 0;
				vel    = 0;
				clears++;
			end else begin
				if (!s.bus_ok)
					last_code = FAULT_BUS;
				else if (!s.mag_present)
					last_code = FAULT_MAG_LOST;
				else if (s.mag_low)
					last_code = FAULT_WEAK;
				else if (s.mag_high)
					last_code = FAULT_STRONG;
				else
					last_code = FAULT_NONE;
				r = s.raw_angle[RB-1:0];
				if (last_code == FAULT_BUS || last_code == FAULT_MAG_LOST) begin
					vel = 0;
					hard_faults++;
				end else if (!seeded) begin
					prev_raw = r;
					count    = 0;
					vel      = 0;
					seeded   = 1'b1;
				end else begin
					d = longint'(r) - longint'(prev_raw);
					if (d > HALF_TURN)
						d -= FULL_TURN;
					else if (d < -HALF_TURN)
						d += FULL_TURN;
					if (invert)
						d = -d;
					prev_raw = r;
					count += d;
					if (count > CNT_MAX)
						count = CNT_MAX;
					if (count < CNT_MIN)
						count = CNT_MIN;
					// floor shift of the Q16 product
					v = vel + ((longint'(alpha) * (d * 65536 - vel)) >>> FRAC_BITS);
					if (v > VEL_MAX || v < VEL_MIN)
						vel_clamps++;
					if (v > VEL_MAX)
						v = VEL_MAX;
					if (v < VEL_MIN)
						v = VEL_MIN;
					vel = v;
				end
			end
			e.fault  = last_code;
			e.total  = count[ACC-1:0];
			e.turns  = (ACC-RB)'(count / FULL_TURN);
			e.vel    = vel[VW-1:0];
			e.seeded = seeded;
			estimates_due.push_back(e);
		endfunction

		function void check_estimate(estimate_t got);
			estimate_t e;
			if (estimates_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t: estimate with nothing outstanding: fault %0d total %0d",
						$realtime, got.fault, got.total);
				return;
			end
			e = estimates_due.pop_front();
			if (got.fault !== e.fault || got.total !== e.total || got.turns !== e.turns ||
					got.vel !== e.vel || got.seeded !== e.seeded) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%t: mismatch exp fault %0d total %0d turns %0d vel %0d seeded %0d",
						$realtime, e.fault, e.total, e.turns, e.vel, e.seeded);
					$display("%t:          got fault %0d total %0d turns %0d vel %0d seeded %0d",
						$realtime, got.fault, got.total, got.turns, got.vel, got.seeded);
				end
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_WIDTH-1:0]  cfg_index;
	logic [CFG_DATA_WIDTH-1:0] cfg_data;

	mtu_in_if  smp_ch();
	mtu_out_if est_ch();

	multiturn_encoder_unwrap_estimator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (smp_ch),
		.result   (est_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	unwrap_tracker tracker = new();
	bit            calm;
	int            walk;
	int            settings_used;
	int            quiet_cycles = 0;

	always #5 clk = ~clk;

	// result channel back-pressure
	always @(posedge clk) begin
		est_ch.ready <= calm || ($urandom_range(99) >= 16);
	end

	always @(posedge clk) begin
		sample_t s;
		if (arst_n && smp_ch.valid && smp_ch.ready) begin
			s.action      = smp_ch.action;
			s.raw_angle   = smp_ch.raw_angle;
			s.bus_ok      = smp_ch.bus_ok;
			s.mag_present = smp_ch.mag_present;
			s.mag_low     = smp_ch.mag_low;
			s.mag_high    = smp_ch.mag_high;
			tracker.take_sample(s);
		end
	end

	always @(posedge clk) begin
		estimate_t got;
		if (arst_n && est_ch.valid && est_ch.ready) begin
			got.fault  = est_ch.fault_code;
			got.total  = est_ch.pos_count;
			got.turns  = est_ch.turns;
			got.vel    = est_ch.velocity;
			got.seeded = est_ch.seeded;
			tracker.check_estimate(got);
		end
	end

	// hang detection: no transaction on either channel for too long
	always @(posedge clk) begin
		if ((smp_ch.valid && smp_ch.ready) || (est_ch.valid && est_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("stalled for %0d cycles with %0d estimates outstanding",
				quiet_cycles, tracker.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic push_sample(sample_t s);
		while (!calm && $urandom_range(99) < 16) begin
			smp_ch.valid <= 1'b0;
			@(posedge clk);
		end
		smp_ch.valid       <= 1'b1;
		smp_ch.action      <= s.action;
		smp_ch.raw_angle   <= s.raw_angle;
		smp_ch.bus_ok      <= s.bus_ok;
		smp_ch.mag_present <= s.mag_present;
		smp_ch.mag_low     <= s.mag_low;
		smp_ch.mag_high    <= s.mag_high;
		do @(posedge clk); while (!smp_ch.ready);
	endtask

	task automatic push_fields(logic act, logic [RAW_WORD_WIDTH-1:0] raw, logic bus,
			logic det, logic lo_field, logic hi_field);
		sample_t s;
		s.action      = act;
		s.raw_angle   = raw;
		s.bus_ok      = bus;
		s.mag_present = det;
		s.mag_low     = lo_field;
		s.mag_high    = hi_field;
		push_sample(s);
	endtask

	task automatic drain();
		smp_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(bit inv, int unsigned a);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_INVERT;
		cfg_data  <= CFG_DATA_WIDTH'(inv);
		@(posedge clk);
		cfg_index <= CFG_WEIGHT;
		cfg_data  <= CFG_DATA_WIDTH'(a);
		@(posedge clk);
		cfg_we    <= 1'b0;
		tracker.configure(inv, a);
		settings_used++;
	endtask

	function automatic sample_t random_sample();
		sample_t s;
		int      pick;
		int      step;
		pick = $urandom_range(99);
		s    = sample_t'(SAMPLE_BITS'($urandom));
		if (pick < 3) begin
			s.action = ACT_CLEAR;
		end else if (pick < 8) begin
			// hard fault with arbitrary flags
			s.action = ACT_SAMPLE;
			if ($urandom_range(1))
				s.bus_ok = 1'b0;
			else begin
				s.bus_ok      = 1'b1;
				s.mag_present = 1'b0;
			end
		end else if (pick >= 13) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: step = int'($urandom_range(64)) - 32;
				6, 7:             step = int'($urandom_range(4095)) - 2048;
				8:                step = $urandom_range(1) ? 2048 : -2048;
				default:          step = int'($urandom_range(8)) - 4;
			endcase
			walk          = (walk + step) & (int'(FULL_TURN) - 1);
			s.action      = ACT_SAMPLE;
			s.raw_angle   = {4'($urandom_range(15)), RB'(walk)};
			s.bus_ok      = 1'b1;
			s.mag_present = 1'b1;
			s.mag_low     = ($urandom_range(99) < 8);
			s.mag_high    = ($urandom_range(99) < 8);
		end
		return s;
	endfunction

	task automatic random_phase(bit inv, int unsigned a, bit no_gaps);
		drain();
		load_settings(inv, a);
		calm = no_gaps;
		repeat (RANDOM_ITEMS)
			push_sample(random_sample());
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		smp_ch.valid       = 1'b0;
		smp_ch.action      = 1'b0;
		smp_ch.raw_angle   = '0;
		smp_ch.bus_ok      = 1'b0;
		smp_ch.mag_present = 1'b0;
		smp_ch.mag_low     = 1'b0;
		smp_ch.mag_high    = 1'b0;
		calm               = 1'b0;
		walk               = 0;
		settings_used      = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pass-through filter, normal direction
		load_settings(1'b0, 65536);
		push_fields(ACT_SAMPLE, 16'hABCD, 1'b0, 1'b0, 1'b1, 1'b1);
		push_fields(ACT_SAMPLE, 16'h1234, 1'b1, 1'b0, 1'b1, 1'b1);
		push_fields(ACT_SAMPLE, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0);
		push_fields(ACT_SAMPLE, 16'hF000, 1'b1, 1'b1, 1'b0, 1'b0);
		push_fields(ACT_SAMPLE, 16'h0800, 1'b1, 1'b1, 1'b0, 1'b0);
		push_fields(ACT_SAMPLE, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0);
		push_fields(ACT_SAMPLE, 16'h0801, 1'b1, 1'b1, 1'b0, 1'b0);
		push_fields(ACT_SAMPLE, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b1);
		push_fields(ACT_SAMPLE, 16'h0FFF, 1'b1, 1'b1, 1'b0, 1'b1);
		push_fields(ACT_SAMPLE, 16'h0555, 1'b0, 1'b1, 1'b0, 1'b0);
		push_fields(ACT_SAMPLE, 16'h0010, 1'b1, 1'b1, 1'b0, 1'b0);
		push_fields(ACT_CLEAR, 16'h5A5A, 1'b0, 1'b1, 1'b0, 1'b1);
		push_fields(ACT_SAMPLE, 16'h0123, 1'b1, 1'b1, 1'b0, 1'b0);
		push_fields(ACT_SAMPLE, 16'h0124, 1'b1, 1'b1, 1'b0, 1'b0);
		push_fields(ACT_CLEAR, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1);
		push_fields(ACT_CLEAR, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0);

		// strongest weight with full half-turn swings: drive the filter into both limits
		drain();
		load_settings(1'b1, 131071);
		push_fields(ACT_SAMPLE, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0);
		repeat (3) begin
			push_fields(ACT_SAMPLE, 16'h0800, 1'b1, 1'b1, 1'b0, 1'b0);
			push_fields(ACT_SAMPLE, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0);
		end
		push_fields(ACT_SAMPLE, 16'h07FF, 1'b1, 1'b1, 1'b0, 1'b0);

		random_phase(1'b0, 0, 1'b0);
		random_phase(1'b1, 65536, 1'b1);
		random_phase(1'b0, 131071, 1'b0);
		random_phase(1'b1, $urandom_range(131071), 1'b0);
		random_phase(1'b0, $urandom_range(1, 4096), 1'b0);
		random_phase(1'b1, 32768, 1'b0);

		drain();
		repeat (8) @(posedge clk);
		if (tracker.pending() != 0)
			tracker.mismatches++;
		$display("Ran %0d samples over %0d register settings: %0d clears, %0d hard faults,",
			tracker.samples, settings_used, tracker.clears, tracker.hard_faults);
		$display("%0d velocity clamps; %0d mismatches, %0d estimates left outstanding",
			tracker.vel_clamps, tracker.mismatches, tracker.pending());
		if (tracker.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
